@@ rtl/glyph_code_binary_search_macros.svh @@
// glyph_code_binary_search_macros.svh: assertion macros for the sorted code table search
// no dependencies; taken in by the top level with `include
`ifndef GLYPH_CODE_BINARY_SEARCH_MACROS_SVH
`define GLYPH_CODE_BINARY_SEARCH_MACROS_SVH

// same-cycle implication, disabled in reset
`define GCBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define GCBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/gcbs_pkg.sv @@
// gcbs_pkg: payload types, controller/datapath command and status, widths
// no dependencies; used by every module of glyph_code_binary_search
package gcbs_pkg;

   localparam int TABLE_DEPTH_DEF = 256;
   localparam int COUNT_W         = 9;
   localparam int SLOT_W          = 8;
   localparam int CODE_W          = 8;

   localparam logic REQ_MODE_LOAD = 1'b0;
   localparam logic REQ_MODE_FIND = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [SLOT_W-1:0] slot;
      logic [CODE_W-1:0] code;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] match_slot;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic start;    // open a new search window
      logic load;     // write one code into the table
      logic advance;  // narrow the window after a miss
      logic finish;   // capture the result beat
   } gcbs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;    // window has closed
      logic hit;      // probed entry equals the code
   } gcbs_sts_type;

endpackage

@@ rtl/gcbs_ctrl.sv @@
// gcbs_ctrl: search sequencer and result valid
// depends on gcbs_pkg
module gcbs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_mode,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gcbs_pkg::gcbs_cmd_type cmd,
   input  gcbs_pkg::gcbs_sts_type sts
);
   import gcbs_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_accept;
   logic      out_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_mode == REQ_MODE_FIND) begin
                  cmd.start = 1'b1;
                  state_in  = ST_SEARCH;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_SEARCH: begin
            if (sts.empty || sts.hit) begin
               // hold the search until the result register is free
               if (out_free) begin
                  cmd.finish   = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/gcbs_dp.sv @@
// gcbs_dp: code table memory, search window, count register and result register
// depends on gcbs_pkg
module gcbs_dp #(
   parameter int TABLE_DEPTH = gcbs_pkg::TABLE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  gcbs_pkg::req_type            req_data,
   output gcbs_pkg::rsp_type            rsp_data,
   input  logic                         csr_wr_en,
   input  logic [gcbs_pkg::COUNT_W-1:0] csr_wr_data,
   input  gcbs_pkg::gcbs_cmd_type       cmd,
   output gcbs_pkg::gcbs_sts_type       sts
);
   import gcbs_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int WIN_W  = ADDR_W + 1;
   localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(TABLE_DEPTH);

   logic [CODE_W-1:0]  code_mem [TABLE_DEPTH];
   logic [CODE_W-1:0]  rd_ff;
   logic [COUNT_W-1:0] entry_count_ff;
   logic [WIN_W-1:0]   lo_ff, lo_in;
   logic [WIN_W-1:0]   hi_ff, hi_in;
   logic [WIN_W-1:0]   mid_ff, mid_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   rsp_type            rsp_ff, rsp_in;
   logic [WIN_W-1:0]   hi_start;
   logic               slot_ok;

   // count above the table size behaves as a full table
   assign hi_start = (entry_count_ff > DEPTH_C) ? WIN_W'(TABLE_DEPTH)
                                                : entry_count_ff[WIN_W-1:0];
   assign slot_ok  = ({1'b0, req_data.slot} < DEPTH_C);

   always_comb begin
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      code_in = code_ff;
      if (cmd.start) begin
         lo_in   = '0;
         hi_in   = hi_start;
         code_in = req_data.code;
      end else if (cmd.advance) begin
         if (rd_ff < code_ff) begin
            lo_in = mid_ff + WIN_W'(1);
         end else begin
            hi_in = mid_ff;
         end
      end
   end

   assign mid_in = lo_in + ((hi_in - lo_in) >> 1);

   assign sts.empty = (lo_ff >= hi_ff);
   assign sts.hit   = (rd_ff == code_ff);

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.finish) begin
         rsp_in.found      = !sts.empty && sts.hit;
         rsp_in.match_slot = rsp_in.found ? SLOT_W'(mid_ff) : '0;
      end
   end

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.load && slot_ok) begin
         code_mem[req_data.slot[ADDR_W-1:0]] <= req_data.code;
      end
      rd_ff <= code_mem[mid_in[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      code_ff <= code_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_wr_en) begin
         entry_count_ff <= csr_wr_data;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ rtl/glyph_code_binary_search.sv @@
// glyph_code_binary_search: top level of the sorted character code table with search
// depends on gcbs_pkg, gcbs_ctrl, gcbs_dp and glyph_code_binary_search_macros.svh
//
// Holds a table of 8-bit character codes, loaded one slot per beat and kept in
// ascending order by the user, and answers find beats by binary search over
// slots 0 to entry_count-1. A load beat (mode 0) returns nothing; a slot at or
// above TABLE_DEPTH is dropped. A find beat (mode 1) returns one beat with
// found and match_slot (zero when not found). An entry_count above TABLE_DEPTH
// searches the whole table, zero gives not found. Timing: one table probe per
// cycle, set by the registered read port of the table memory, and at most 9
// probes with a full 256-entry table; a find holds the input until its result
// is in the output register. The result sits in an output register, so a load
// can be taken while a result beat waits; a find that completes while the
// previous result is still stalled holds until it drains. The table has no
// reset: slots must be loaded before a search can reach them. The user must
// write entry_count only while no find is in flight; the block itself does
// not enforce it.
module glyph_code_binary_search #(
   parameter int TABLE_DEPTH = gcbs_pkg::TABLE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  gcbs_pkg::req_type            req_data,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output gcbs_pkg::rsp_type            rsp_data,
   // entry_count register
   input  logic                         csr_wr_en,
   input  logic [gcbs_pkg::COUNT_W-1:0] csr_wr_data
);
   import gcbs_pkg::*;

   `include "glyph_code_binary_search_macros.svh"

   gcbs_cmd_type cmd;
   gcbs_sts_type sts;

   // sequencer: accepts beats only when idle, steps the search, owns rsp_valid
   gcbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // table memory, lo/hi window, probe compare and result register
   gcbs_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

   // a miss always reports slot zero
   `GCBS_ASSERT_NOW(a_miss_slot_zero, clock, reset, rsp_valid && !rsp_data.found, rsp_data.match_slot == '0, "miss with nonzero slot")
   // an accepted find blocks the input on the next cycle
   `GCBS_ASSERT_NEXT(a_find_busy, clock, reset, req_valid && !req_stall && req_data.mode == REQ_MODE_FIND, req_stall, "find did not start a search")
   // a load accepted while no result is pending produces no result beat
   `GCBS_ASSERT_NEXT(a_load_silent, clock, reset, req_valid && !req_stall && req_data.mode == REQ_MODE_LOAD && !rsp_valid, !rsp_valid, "load produced a result")
   // a new result is only presented once the window closed or hit
   `GCBS_ASSERT_NOW(a_finish_cond, clock, reset, cmd.finish, sts.empty || sts.hit, "search finished early")

endmodule
